/* rtl/free_list_slot_allocator_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the free list slot allocator
// Shared helpers for the checker module.
// ---------------------------------------------------------------------------
`ifndef FREE_LIST_SLOT_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FLA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FLA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fla_pkg.sv */
// ---------------------------------------------------------------------------
// fla_pkg
// Constants, opcodes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package fla_pkg;

  localparam int POOL_SLOTS = 256;
  localparam int SLOT_W     = 8;
  localparam int LINK_W     = 9;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SLOTS);
  localparam logic [LINK_W-1:0] POOL_TOP  = LINK_W'(POOL_SLOTS - 1);

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef struct packed {
    logic push;        // release: link slot in front of head
    logic pop_start;   // acquire: read link of head
    logic pop_finish;  // acquire: advance head, load result
    logic fail;        // load a failure result
  } ctl_cmd_t;

  typedef struct packed {
    logic head_null;
    logic slot_ok;
  } dp_status_t;

endpackage

/* rtl/fla_ctrl.sv */
// ---------------------------------------------------------------------------
// fla_ctrl
// Sequencer for the allocator: request handshake, pop state, output valid.
// ---------------------------------------------------------------------------
module fla_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                opcode,
  output logic                out_valid,
  input  logic                out_stall,
  output fla_pkg::ctl_cmd_t   cmd,
  input  fla_pkg::dp_status_t status
);
  import fla_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   accept;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_RELEASE) begin
            if (status.slot_ok) cmd.push = 1'b1;
            else                cmd.fail = 1'b1;
          end else if (status.head_null) begin
            cmd.fail = 1'b1;
          end else begin
            cmd.pop_start = 1'b1;
            state_next    = S_POP;
          end
        end
      end
      S_POP: begin
        cmd.pop_finish = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.push || cmd.fail || cmd.pop_finish) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* rtl/fla_datapath.sv */
// ---------------------------------------------------------------------------
// fla_datapath
// Link memory, head pointer, free count and result register.
// ---------------------------------------------------------------------------
module fla_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  fla_pkg::ctl_cmd_t          cmd,
  output fla_pkg::dp_status_t        status,
  input  logic [fla_pkg::SLOT_W-1:0] slot_in,
  output logic                       granted,
  output logic [fla_pkg::SLOT_W-1:0] slot_out,
  output logic [fla_pkg::LINK_W-1:0] free_count
);
  import fla_pkg::*;

  logic [LINK_W-1:0]     mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] written;
  logic [LINK_W-1:0]     head;
  logic [LINK_W-1:0]     free_total;
  logic [LINK_W-1:0]     free_total_next;
  logic [LINK_W-1:0]     rd_data;
  logic                  rd_written;
  logic [LINK_W-1:0]     link;
  logic [SLOT_W-1:0]     head_idx;

  assign head_idx         = head[SLOT_W-1:0];
  assign status.head_null = (head >= NULL_LINK);
  assign status.slot_ok   = (LINK_W'(slot_in) < NULL_LINK);

  // Never-written entries hold the reset chain: slot i -> i-1, slot 0 -> null.
  always_comb begin
    if (rd_written)            link = rd_data;
    else if (head_idx == '0)   link = NULL_LINK;
    else                       link = head - LINK_W'(1);
  end

  always_comb begin
    free_total_next = free_total;
    if (cmd.push && (free_total < NULL_LINK))
      free_total_next = free_total + LINK_W'(1);
    else if (cmd.pop_finish && (free_total != '0))
      free_total_next = free_total - LINK_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.push) mem[slot_in] <= head;
    if (cmd.pop_start) rd_data <= mem[head_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      head       <= POOL_TOP;
      free_total <= NULL_LINK;
      rd_written <= 1'b0;
    end else begin
      if (cmd.push) begin
        written[slot_in] <= 1'b1;
        head             <= LINK_W'(slot_in);
      end else if (cmd.pop_finish) begin
        head <= (link > NULL_LINK) ? NULL_LINK : link;
      end
      if (cmd.pop_start) rd_written <= written[head_idx];
      free_total <= free_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      granted    <= 1'b1;
      slot_out   <= slot_in;
      free_count <= free_total_next;
    end else if (cmd.pop_finish) begin
      granted    <= 1'b1;
      slot_out   <= head_idx;
      free_count <= free_total_next;
    end else if (cmd.fail) begin
      granted    <= 1'b0;
      slot_out   <= '0;
      free_count <= free_total;
    end
  end

endmodule

/* rtl/free_list_slot_allocator.sv */
// ---------------------------------------------------------------------------
// free_list_slot_allocator
// LIFO free list over a fixed pool of slots, one result per request.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries opcode and slot_in. An acquire
//   pops the head of the free list; a release pushes slot_in as new head.
//   Output channel (out_valid/out_stall) returns granted, slot_out and the
//   free count after the request. Every request gives exactly one result.
// Timing:
//   Release and a failed acquire: result is valid in the cycle after acceptance.
//   Successful acquire: passes through S_POP for the synchronous read of the
//   link memory at the head slot before the head can advance.
//   Sustained rate: one request per cycle for releases while out_stall is low;
//   an acquire holds off new requests in S_POP. One request at a time.
// Stall:
//   The result register holds while out_stall is high; a new request is
//   accepted in the same cycle the pending result is taken.
// Reset:
//   The list runs from the top slot down to slot 0 and the count is full.
//   Per-entry written flags stand in for the initial link chain, so there
//   is no clearing pass; requests are taken in the first cycle after reset.
// ---------------------------------------------------------------------------
module free_list_slot_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       opcode,
  input  logic [fla_pkg::SLOT_W-1:0] slot_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       granted,
  output logic [fla_pkg::SLOT_W-1:0] slot_out,
  output logic [fla_pkg::LINK_W-1:0] free_count
);
  import fla_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // Sequencer: handshake, pop wait state, result valid.
  fla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Link memory, head, count and the result register.
  fla_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .slot_in    (slot_in),
    .granted    (granted),
    .slot_out   (slot_out),
    .free_count (free_count)
  );

endmodule

/* rtl/fla_checker.sv */
// ---------------------------------------------------------------------------
// fla_checker
// Port-level checks for the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "free_list_slot_allocator_assert.svh"

module fla_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       opcode,
  input logic [fla_pkg::SLOT_W-1:0] slot_in,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       granted,
  input logic [fla_pkg::SLOT_W-1:0] slot_out,
  input logic [fla_pkg::LINK_W-1:0] free_count
);
  import fla_pkg::*;

  logic rel_accept;
  assign rel_accept = in_valid && !in_stall && (opcode == OP_RELEASE);

  // A failed request reports slot zero.
  `FLA_ASSERT_NOW(a_fail_slot_zero, clk, rst, out_valid && !granted, slot_out == '0, "fail slot")

  // The count never passes the pool size.
  `FLA_ASSERT_NOW(a_count_bound, clk, rst, out_valid, free_count <= NULL_LINK, "count bound")

  // A release is granted next cycle and echoes its slot.
  `FLA_ASSERT_NEXT(a_release_echo, clk, rst, rel_accept, out_valid && granted && slot_out == $past(slot_in), "release echo")

  // A stalled result holds.
  `FLA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(slot_out) && $stable(free_count), "stalled result moved")

endmodule

bind free_list_slot_allocator fla_checker u_fla_checker (.*);

/* test/free_list_slot_allocator_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// free_list_slot_allocator_test
// Self-checking bench for the LIFO slot allocator. A scoreboard class keeps
// its own copy of the link table, head and free count. It predicts each
// result when a request is accepted and compares every returned result,
// field by field, in order. Requests start with a short directed run, then
// go to well-formed random acquire/release traffic. Double releases are
// added as noise in the last phase. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module free_list_slot_allocator_test;
  import fla_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 8;
  localparam int PHASE_ITEMS  = 100;
  localparam int REPORT_LINES = 40;

  // One predicted result of the block.
  typedef struct {
    logic              granted;
    logic [SLOT_W-1:0] slot;
    logic [LINK_W-1:0] count;
  } alloc_result_t;

  // Predicts the allocator and checks its results in order.
  class slot_scoreboard;
    logic [LINK_W-1:0] link_of [POOL_SLOTS];
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] free_total;
    alloc_result_t     owed [$];
    logic [SLOT_W-1:0] held [$];
    int unsigned       results_seen;
    int unsigned       mismatches;

    function new();
      // The chain runs from the top slot down to slot 0.
      link_of[0] = NULL_LINK;
      for (int i = 1; i < POOL_SLOTS; i++) link_of[i] = LINK_W'(i - 1);
      head         = POOL_TOP;
      free_total   = LINK_W'(POOL_SLOTS);
      results_seen = 0;
      mismatches   = 0;
    endfunction

    // Advance the predicted list by one accepted request.
    function void note_request(op_t op, logic [SLOT_W-1:0] slot);
      alloc_result_t r;
      r.granted = 1'b0;
      r.slot    = '0;
      if (op == OP_ACQUIRE) begin
        // Emptiness is decided by the head alone, not by the count.
        if (head < NULL_LINK) begin
          r.granted = 1'b1;
          r.slot    = head[SLOT_W-1:0];
          head      = link_of[head[SLOT_W-1:0]];
          if (free_total != 0) free_total--;
          held.push_back(r.slot);
        end
      end else if (int'(slot) < POOL_SLOTS) begin
        link_of[slot] = head;
        head          = LINK_W'(slot);
        if (free_total < LINK_W'(POOL_SLOTS)) free_total++;
        r.granted     = 1'b1;
        r.slot        = slot;
      end
      r.count = free_total;
      owed.push_back(r);
    endfunction

    task report(string what, logic [LINK_W-1:0] got, logic [LINK_W-1:0] want);
      if (mismatches < REPORT_LINES)
        $display("result %0d: %s is %0d, want %0d", results_seen, what, got, want);
      mismatches++;
    endtask

    task check_result(logic g, logic [SLOT_W-1:0] s, logic [LINK_W-1:0] fc);
      alloc_result_t want;
      results_seen++;
      if (owed.size() == 0) begin
        report("unrequested result, slot", LINK_W'(s), '0);
        return;
      end
      want = owed.pop_front();
      if (g !== want.granted) report("granted", LINK_W'(g), LINK_W'(want.granted));
      if (s !== want.slot) report("slot_out", LINK_W'(s), LINK_W'(want.slot));
      if (fc !== want.count) report("free_count", fc, want.count);
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              opcode = 1'b0;
  logic [SLOT_W-1:0] slot_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              granted;
  logic [SLOT_W-1:0] slot_out;
  logic [LINK_W-1:0] free_count;

  slot_scoreboard board;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    cycle_count = 0;
  int unsigned    hold_token = 0;
  int unsigned    hold_seen = 0;
  int unsigned    hold_left = 0;

  free_list_slot_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .slot_in   (slot_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .granted   (granted),
    .slot_out  (slot_out),
    .free_count(free_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("free_list_slot_allocator_test failed");
      $finish;
    end
  end

  // Result side: check every taken result, then pick the next stall. A new
  // hold_token value starts a long hold, counted down here, so that the
  // block backs up and stalls the request side.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) board.check_result(granted, slot_out, free_count);
      if (hold_token != hold_seen) begin
        hold_seen <= hold_token;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Offer one request, idling first at random. Hold the payload until the
  // block takes it, then note it with the scoreboard. Entered and left
  // just after a rising edge.
  task send_request(input op_t op, input logic [SLOT_W-1:0] slot);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    slot_in  <= slot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(op, slot);
  endtask

  // Release a slot the bench holds; drop it from the held set first.
  task give_back(input logic [SLOT_W-1:0] slot);
    int found [$];
    found = board.held.find_first_index(x) with (x == slot);
    if (found.size() != 0) board.held.delete(found[0]);
    send_request(OP_RELEASE, slot);
  endtask

  // Pause requests until every predicted result has come back.
  task wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
  endtask

  // Acquire until the list is empty, then try a few more on the empty list.
  task drain_list();
    int unsigned guard;
    guard = 0;
    while (board.head < NULL_LINK && guard < 600) begin
      send_request(OP_ACQUIRE, SLOT_W'($urandom));
      guard++;
    end
    repeat (2) send_request(OP_ACQUIRE, SLOT_W'($urandom));
  endtask

  // Random traffic in stretches of a fixed acquire mix, from mostly
  // releasing to mostly acquiring. Releases return held slots; noise_pct
  // of them name a random slot instead, which may be a double release.
  task run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                 input int unsigned noise_pct);
    int unsigned n;
    int unsigned acq_pct;
    int unsigned pick;
    logic [SLOT_W-1:0] slot;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    acq_pct = 50;
    drain_list();
    for (n = 0; n < PHASE_ITEMS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 3))
          0:       acq_pct = 10;
          1:       acq_pct = 50;
          2:       acq_pct = 90;
          default: acq_pct = 98;
        endcase
      end
      // Halfway through, hold off the result side for a long stretch.
      if (n == PHASE_ITEMS / 2) hold_token <= hold_token + 1;
      if ($urandom_range(0, 99) < acq_pct) begin
        send_request(OP_ACQUIRE, SLOT_W'($urandom));
      end else if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 7))
          0:       slot = '0;
          1:       slot = '1;
          default: slot = SLOT_W'($urandom);
        endcase
        send_request(OP_RELEASE, slot);
      end else if (board.held.size() != 0) begin
        pick = $urandom_range(0, board.held.size() - 1);
        give_back(board.held[pick]);
      end else begin
        send_request(OP_ACQUIRE, SLOT_W'($urandom));
      end
    end
    wait_drained();
  endtask

  initial begin
    board = new();
    send_idle_pct  = 20;
    recv_stall_pct = 78;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: first acquires come from the top of the pool, releases
    // go back in LIFO order. slot_in is ignored on acquire.
    send_request(OP_ACQUIRE, '1);
    send_request(OP_ACQUIRE, '0);
    give_back(SLOT_W'(POOL_SLOTS - 1));
    give_back(SLOT_W'(POOL_SLOTS - 2));
    send_request(OP_ACQUIRE, SLOT_W'(8'h55));
    send_request(OP_ACQUIRE, SLOT_W'(8'hAA));
    give_back(SLOT_W'(POOL_SLOTS - 2));
    give_back(SLOT_W'(POOL_SLOTS - 1));

    // Empty list: drain the whole pool, then use the lowest and highest
    // slots as the only free ones.
    drain_list();
    give_back('0);
    give_back('1);
    send_request(OP_ACQUIRE, '0);
    send_request(OP_ACQUIRE, '1);
    send_request(OP_ACQUIRE, '0);

    // Refill to a full pool.
    while (board.held.size() != 0) give_back(board.held[0]);
    wait_drained();

    // Sender idles lightly, receiver stalls often; well-formed traffic.
    run_phase(20, 78, 0);
    // The other way round.
    run_phase(78, 20, 0);

    // No idling. Start with a double release on an otherwise empty list:
    // the slot links to itself and acquires keep granting it while the
    // count bottoms out at zero.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain_list();
    give_back(SLOT_W'(3));
    send_request(OP_RELEASE, SLOT_W'(3));
    repeat (3) send_request(OP_ACQUIRE, SLOT_W'($urandom));
    // Release on a full count: the count saturates at the pool size.
    while (board.held.size() != 0) give_back(board.held[0]);
    send_request(OP_RELEASE, SLOT_W'(3));
    run_phase(0, 0, 15);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("free_list_slot_allocator_test passed");
    end else begin
      $display("free_list_slot_allocator_test failed");
    end
    $finish;
  end

endmodule
